### rtl/core/spq_pkg.sv
// Package for the sorted priority queue: sizes, field types, operation codes
// and the control word that the top level broadcasts to the row of cells.
// Depends on nothing; every other file imports it.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS = 16;
  localparam int TAG_BITS = 8;
  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Operation requested by an input transfer.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_POP_HEAD = 2'd1;
  localparam logic [1:0] MODE_POP_TAIL = 2'd2;

  // Status reported with every result.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Per-cycle command seen by every cell.
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_POP_HEAD = 2'd2;
  localparam logic [1:0] CELL_POP_TAIL = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       descending;
    key_t       key;
    tag_t       tag;
  } cell_ctrl_t;

endpackage

### rtl/core/spq_cell.sv
// One slot of the sorted queue: holds an entry and its used bit, decides
// locally whether to keep, take the new entry, or take a neighbor's entry.
// Depends on spq_pkg.
module spq_cell (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::key_t     left_priority,
  input  spq_pkg::tag_t     left_tag,
  input  logic              left_used,
  input  logic              left_found,
  input  spq_pkg::key_t     right_priority,
  input  spq_pkg::tag_t     right_tag,
  input  logic              right_used,
  output spq_pkg::key_t     slot_priority,
  output spq_pkg::tag_t     slot_tag,
  output logic              slot_used,
  output logic              found
);
  import spq_pkg::*;

  logic ahead;

  // The held entry strictly precedes the new key in the current direction.
  assign ahead = slot_used &&
                 (ctrl.descending ? (slot_priority > ctrl.key)
                                  : (slot_priority < ctrl.key));

  // The insert position lies at or ahead of this cell.
  assign found = left_found || !ahead;

  // Occupancy moves one place toward the tail on insert, toward the head on pops.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_INSERT: begin
          slot_used <= left_used;
        end
        CELL_POP_HEAD, CELL_POP_TAIL: begin
          slot_used <= right_used;
        end
        default: begin
          slot_used <= slot_used;
        end
      endcase
    end
  end

  // Entry data: the insert point takes the new entry and the cells behind it shift
  // toward the tail; a head pop shifts toward the head; a tail pop keeps the data.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (left_found) begin
          slot_priority <= left_priority;
          slot_tag <= left_tag;
        end else if (!ahead) begin
          slot_priority <= ctrl.key;
          slot_tag <= ctrl.tag;
        end
      end
      CELL_POP_HEAD: begin
        slot_priority <= right_priority;
        slot_tag <= right_tag;
      end
      default: begin
        slot_priority <= slot_priority;
        slot_tag <= slot_tag;
      end
    endcase
  end

endmodule

### rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: handshakes, count, direction
// register, the row of spq_cell slots and the registered result stage.
// Depends on spq_pkg and spq_cell.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------------
//   input    | in        | in_valid/in_stall  | mode, priority_req, tag
//   result   | out       | res_valid/res_stall| out_valid, out_priority, out_tag,
//            |           |                    | status, count
//   config   | in        | cfg_write_enable   | cfg_write_data (order_descending)
//
// Every operation finishes in the cycle of its transfer: all cells compare and
// shift at once, and the result is captured in the output register at the same edge.
// A new item is taken every cycle while the result register is free or drains.
// The insert position is found by a found chain rippling through the cells.
// Synchronous reset empties the queue and sets descending order.
// While a result is held stalled, in_stall is raised.
module sorted_priority_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_enable,
  input  logic              cfg_write_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        mode,
  input  spq_pkg::key_t     priority_req,
  input  spq_pkg::tag_t     tag,
  output logic              res_valid,
  input  logic              res_stall,
  output logic              out_valid,
  output spq_pkg::key_t     out_priority,
  output spq_pkg::tag_t     out_tag,
  output logic [1:0]        status,
  output spq_pkg::count_t   count
);
  import spq_pkg::*;

  logic       order_descending;
  count_t     held_count;
  count_t     held_count_next;
  logic       accept;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;

  key_t cell_priority [QUEUE_DEPTH];
  tag_t cell_tag [QUEUE_DEPTH];
  logic [QUEUE_DEPTH+1:0] used_ext;
  logic [QUEUE_DEPTH:0] found_chain;

  logic       out_valid_next;
  key_t       out_priority_next;
  tag_t       out_tag_next;
  logic [1:0] status_next;
  key_t       tail_priority;
  tag_t       tail_tag;

  // Input transfer completes whenever the result register can take a result.
  assign in_stall = res_valid && res_stall;
  assign accept = in_valid && !in_stall;
  assign full = (held_count == COUNT_BITS'(QUEUE_DEPTH));
  assign empty = (held_count == '0);

  // Direction register.
  always_ff @(posedge clk) begin
    if (rst) begin
      order_descending <= 1'b1;
    end else if (cfg_write_enable) begin
      order_descending <= cfg_write_data;
    end
  end

  // Command broadcast to the row of cells.
  always_comb begin
    ctrl.descending = order_descending;
    ctrl.key = priority_req;
    ctrl.tag = tag;
    ctrl.op = CELL_HOLD;
    if (accept) begin
      case (mode)
        MODE_INSERT: begin
          if (!full) ctrl.op = CELL_INSERT;
        end
        MODE_POP_HEAD: begin
          if (!empty) ctrl.op = CELL_POP_HEAD;
        end
        MODE_POP_TAIL: begin
          if (!empty) ctrl.op = CELL_POP_TAIL;
        end
        default: begin
          ctrl.op = CELL_HOLD;
        end
      endcase
    end
  end

  // Row of cells; the ends see an always-used left and never-used right.
  assign used_ext[0] = 1'b1;
  assign used_ext[QUEUE_DEPTH+1] = 1'b0;
  assign found_chain[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int LEFT = (i == 0) ? 0 : i - 1;
    localparam int RIGHT = (i == QUEUE_DEPTH - 1) ? i : i + 1;

    spq_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .left_priority  (cell_priority[LEFT]),
      .left_tag       (cell_tag[LEFT]),
      .left_used      (used_ext[i]),
      .left_found     (found_chain[i]),
      .right_priority (cell_priority[RIGHT]),
      .right_tag      (cell_tag[RIGHT]),
      .right_used     (used_ext[i+2]),
      .slot_priority  (cell_priority[i]),
      .slot_tag       (cell_tag[i]),
      .slot_used      (used_ext[i+1]),
      .found          (found_chain[i+1])
    );
  end

  // The tail entry is the last used cell; its select is one-hot, or zero when empty.
  always_comb begin
    tail_priority = '0;
    tail_tag = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (used_ext[i+1] && !used_ext[i+2]) begin
        tail_priority = tail_priority | cell_priority[i];
        tail_tag = tail_tag | cell_tag[i];
      end
    end
  end

  // Result fields and the count after this operation.
  always_comb begin
    out_valid_next = 1'b0;
    out_priority_next = '0;
    out_tag_next = '0;
    status_next = ST_DONE;
    held_count_next = held_count;
    case (mode)
      MODE_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          held_count_next = held_count + COUNT_BITS'(1);
        end
      end
      MODE_POP_HEAD: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          out_valid_next = 1'b1;
          out_priority_next = cell_priority[0];
          out_tag_next = cell_tag[0];
          held_count_next = held_count - COUNT_BITS'(1);
        end
      end
      MODE_POP_TAIL: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          out_valid_next = 1'b1;
          out_priority_next = tail_priority;
          out_tag_next = tail_tag;
          held_count_next = held_count - COUNT_BITS'(1);
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // Count and result handshake state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) held_count <= held_count_next;
      res_valid <= accept || (res_valid && res_stall);
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_valid <= out_valid_next;
      out_priority <= out_priority_next;
      out_tag <= out_tag_next;
      status <= status_next;
      count <= held_count_next;
    end
  end

`ifndef SYNTHESIS
  // Occupied cells always match the held count.
  a_used_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(used_ext[QUEUE_DEPTH:1]) == int'(held_count))
    else $error("cell occupancy differs from held count");

  // A refused insert is only reported with a full queue.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_FULL) |-> (count == COUNT_BITS'(QUEUE_DEPTH)))
    else $error("full status without a full queue");

  // A returned entry always comes with a done status.
  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_valid) |-> (status == ST_DONE))
    else $error("returned entry with error status");

  // The count holds still in any cycle without an input transfer.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(held_count))
    else $error("count changed without a transfer");
`endif

endmodule
